[sv/tcce_pkg.sv]
// Shared types and constants of the text console character engine.
`timescale 1ns / 1ps
`default_nettype none

package tcce_pkg;

    // Result kinds carried on the result channel.
    typedef enum logic [1:0] {
        KIND_CELL   = 2'd0,
        KIND_SCROLL = 2'd1,
        KIND_CLEAR  = 2'd2,
        KIND_CURSOR = 2'd3
    } kind_t;

    // Most results that one input word may cause, and the width of a count of them.
    localparam int MAX_RESULTS = 9;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    // Character codes with a meaning of their own.
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CH_QMARK = 8'h3F;

    // Input command codes.
    localparam logic CMD_PUT   = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    // Register file: address width and register indexes (index is paddr[2]).
    localparam int   APB_ADDR_W = 3;
    localparam logic REG_FG     = 1'b0;
    localparam logic REG_BG     = 1'b1;

    // Register reset values.
    localparam logic [7:0] FG_RESET = 8'd15;
    localparam logic [7:0] BG_RESET = 8'd0;

endpackage

`default_nettype wire

[sv/tcce_regs.sv]
// Colour register file behind the APB-style configuration port.
`timescale 1ns / 1ps
`default_nettype none

module tcce_regs
    import tcce_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready,
    output logic      [7:0]            attr_byte
);

    logic [7:0] fg_reg;
    logic [7:0] bg_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Register writes complete in the access phase.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fg_reg <= FG_RESET;
            bg_reg <= BG_RESET;
        end else if (wr_en) begin
            case (paddr[2])
                REG_FG: begin
                    fg_reg <= pwdata[7:0];
                end
                REG_BG: begin
                    bg_reg <= pwdata[7:0];
                end
                default: begin
                    fg_reg <= fg_reg;
                end
            endcase
        end
    end

    // Read-back multiplexer.
    always_comb begin
        case (paddr[2])
            REG_FG:  prdata = {24'd0, fg_reg};
            REG_BG:  prdata = {24'd0, bg_reg};
            default: prdata = 32'd0;
        endcase
    end

    // The attribute byte of every cell word is the OR of both colour registers.
    assign attr_byte = fg_reg | bg_reg;

endmodule

`default_nettype wire

[sv/text_console_char_engine_unit.sv]
// Path: input word -> input register -> step logic -> result register -> m_.
// Throughput: one result word per cycle unless m_ready stalls; a printed byte that
// scrolls gives a cell and a scroll result, and a tab gives up to nine results.
// The input register holds the word while its results are issued, as m_ready allows.
// Reset homes the cursor (row 0, column 0), sets foreground 15 and background 0.
`timescale 1ns / 1ps
`default_nettype none

module text_console_char_engine_unit
    import tcce_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 80,
    parameter int SCREEN_HEIGHT = 25,
    parameter int TAB_STOP      = 8
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // Configuration port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready,
    // Input channel
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_command,
    input  wire logic [7:0]            s_char_byte,
    // Result channel
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic      [1:0]            m_kind,
    output logic      [4:0]            m_cell_row,
    output logic      [6:0]            m_cell_col,
    output logic      [15:0]           m_cell_word,
    output logic      [4:0]            m_cursor_row,
    output logic      [6:0]            m_cursor_col,
    output logic      [10:0]           m_cursor_addr,
    output logic                       m_last
);

    localparam int COL_W  = $clog2(SCREEN_WIDTH);
    localparam int ROW_W  = $clog2(SCREEN_HEIGHT);
    localparam int TAB_W  = $clog2(TAB_STOP + 1);
    localparam int ADDR_W = $clog2(SCREEN_WIDTH * SCREEN_HEIGHT);

    localparam logic [COL_W:0]     COL_LIMIT = (COL_W + 1)'(SCREEN_WIDTH);
    localparam logic [ROW_W:0]     ROW_LIMIT = (ROW_W + 1)'(SCREEN_HEIGHT);
    localparam logic [ROW_W-1:0]   ROW_LAST  = ROW_W'(SCREEN_HEIGHT - 1);
    localparam logic [TAB_W-1:0]   TAB_LIMIT = TAB_W'(TAB_STOP);
    localparam logic [TAB_W-1:0]   TAB_TOP   = TAB_W'(TAB_STOP - 1);
    localparam logic [ADDR_W-1:0]  ADDR_MULT = ADDR_W'(SCREEN_WIDTH);

    // Input register
    logic              item_valid_reg;
    logic              item_cmd_reg;
    logic [7:0]        item_byte_reg;

    // Progress through the results of the held word
    logic              started_reg;
    logic              pend_reg;
    logic [TAB_W-1:0]  tab_left_reg;
    logic [CNT_W-1:0]  cnt_reg;

    // Cursor state; phase is the column modulo the tab stop
    logic [ROW_W-1:0]  row_reg;
    logic [COL_W-1:0]  col_reg;
    logic [TAB_W-1:0]  phase_reg;

    // Result register
    logic              out_valid_reg;
    kind_t             out_kind_reg;
    logic [ROW_W-1:0]  out_cell_row_reg;
    logic [COL_W-1:0]  out_cell_col_reg;
    logic [15:0]       out_word_reg;
    logic [ROW_W-1:0]  out_cur_row_reg;
    logic [COL_W-1:0]  out_cur_col_reg;
    logic [ADDR_W-1:0] out_addr_reg;
    logic              out_last_reg;

    logic [7:0]        attr_byte;
    logic              out_free;
    logic              step_go;
    logic              retire;

    // Step results
    logic              emit;
    logic              done;
    kind_t             kind_n;
    logic [ROW_W-1:0]  cell_row_n;
    logic [COL_W-1:0]  cell_col_n;
    logic [15:0]       word_n;
    logic [ROW_W-1:0]  row_next;
    logic [COL_W-1:0]  col_next;
    logic [TAB_W-1:0]  phase_next;
    logic              pend_next;
    logic [TAB_W-1:0]  tab_left_next;
    logic [ADDR_W-1:0] addr_n;

    // Helpers
    logic [COL_W:0]    col_inc;
    logic              wrap;
    logic [ROW_W:0]    row_inc;
    logic              bottom;
    logic [ROW_W-1:0]  row_down;
    logic [TAB_W-1:0]  phase_inc;
    logic [TAB_W-1:0]  phase_dec;
    logic [TAB_W-1:0]  tab_cur;
    logic [CNT_W-1:0]  cnt_inc;
    logic [15:0]       fill_word;
    logic              is_tab;
    logic [7:0]        put_code;

    // True when a tab with n spaces left, c results given and the cursor at
    // column col gives no more results.
    function automatic logic tab_finished(
        input logic [TAB_W-1:0] n,
        input logic [CNT_W-1:0] c,
        input logic [COL_W-1:0] col
    );
        logic room_for_pair;
        logic room_for_one;
        room_for_pair = c < CNT_W'(MAX_RESULTS - 1);
        room_for_one  = (c < CNT_W'(MAX_RESULTS)) && (({1'b0, col} + 1'b1) < COL_LIMIT);
        return (n == '0) || (!room_for_pair && !room_for_one);
    endfunction

    tcce_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .attr_byte (attr_byte)
    );

    // Handshake: the held word steps whenever the result register can take a word.
    assign out_free = !out_valid_reg || m_ready;
    assign step_go  = item_valid_reg && out_free;
    assign retire   = step_go && done;
    assign s_ready  = !item_valid_reg || retire;

    // Cursor arithmetic shared by the step logic.
    assign col_inc   = {1'b0, col_reg} + 1'b1;
    assign wrap      = col_inc >= COL_LIMIT;
    assign row_inc   = {1'b0, row_reg} + 1'b1;
    assign bottom    = row_inc >= ROW_LIMIT;
    assign row_down  = bottom ? ROW_LAST : row_inc[ROW_W-1:0];
    assign phase_inc = (phase_reg == TAB_TOP) ? '0 : phase_reg + 1'b1;
    assign phase_dec = (phase_reg == '0) ? TAB_TOP : phase_reg - 1'b1;
    assign tab_cur   = started_reg ? tab_left_reg : TAB_LIMIT - phase_reg;
    assign cnt_inc   = (started_reg ? cnt_reg : '0) + 1'b1;
    assign fill_word = {attr_byte, CH_SPACE};
    assign is_tab    = (item_byte_reg == CH_TAB);
    assign put_code  = is_tab ? CH_SPACE : (item_byte_reg[7] ? CH_QMARK : item_byte_reg);

    // One step of the held word: the next result and the cursor after it.
    always_comb begin
        emit          = 1'b0;
        done          = 1'b1;
        kind_n        = KIND_CURSOR;
        cell_row_n    = '0;
        cell_col_n    = '0;
        word_n        = 16'd0;
        row_next      = row_reg;
        col_next      = col_reg;
        phase_next    = phase_reg;
        pend_next     = 1'b0;
        tab_left_next = tab_cur;

        if (item_cmd_reg == CMD_CLEAR) begin
            emit       = 1'b1;
            kind_n     = KIND_CLEAR;
            word_n     = fill_word;
            row_next   = '0;
            col_next   = '0;
            phase_next = '0;
        end else if (is_tab || (item_byte_reg >= CH_SPACE && item_byte_reg != CH_DEL)) begin
            // Cell write, or the scroll that a wrap at the bottom left pending.
            emit = 1'b1;
            if (pend_reg) begin
                kind_n = KIND_SCROLL;
                word_n = fill_word;
                done   = is_tab ? tab_finished(tab_cur, cnt_inc, col_reg) : 1'b1;
            end else begin
                kind_n        = KIND_CELL;
                cell_row_n    = row_reg;
                cell_col_n    = col_reg;
                word_n        = {attr_byte, put_code};
                tab_left_next = tab_cur - 1'b1;
                if (wrap) begin
                    col_next   = '0;
                    phase_next = '0;
                    row_next   = row_down;
                    pend_next  = bottom;
                end else begin
                    col_next   = col_inc[COL_W-1:0];
                    phase_next = phase_inc;
                end
                if (wrap && bottom) begin
                    done = 1'b0;
                end else begin
                    done = is_tab ? tab_finished(tab_cur - 1'b1, cnt_inc, col_next) : 1'b1;
                end
            end
        end else begin
            // Cursor controls; other control bytes and DEL give nothing.
            case (item_byte_reg)
                CH_BS: begin
                    if (col_reg != '0) begin
                        emit       = 1'b1;
                        col_next   = col_reg - 1'b1;
                        phase_next = phase_dec;
                    end
                end
                CH_LF, CH_VT, CH_FF: begin
                    emit     = 1'b1;
                    row_next = row_down;
                    if (item_byte_reg == CH_LF) begin
                        col_next   = '0;
                        phase_next = '0;
                    end
                    if (bottom) begin
                        kind_n = KIND_SCROLL;
                        word_n = fill_word;
                    end
                end
                CH_CR: begin
                    emit       = 1'b1;
                    col_next   = '0;
                    phase_next = '0;
                end
                default: begin
                    emit = 1'b0;
                end
            endcase
        end
    end

    // Linear cursor address of the new position.
    assign addr_n = ADDR_W'(row_next) * ADDR_MULT + ADDR_W'(col_next);

    // Control state: input register, step progress, cursor, result valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
            started_reg    <= 1'b0;
            pend_reg       <= 1'b0;
            row_reg        <= '0;
            col_reg        <= '0;
            phase_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                item_valid_reg <= 1'b1;
            end else if (retire) begin
                item_valid_reg <= 1'b0;
            end

            if (step_go) begin
                row_reg     <= row_next;
                col_reg     <= col_next;
                phase_reg   <= phase_next;
                started_reg <= !done;
                pend_reg    <= !done && pend_next;
            end

            if (step_go && emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_cmd_reg  <= s_command;
            item_byte_reg <= s_char_byte;
        end
        if (step_go && !done) begin
            tab_left_reg <= tab_left_next;
            cnt_reg      <= cnt_inc;
        end
        if (step_go && emit) begin
            out_kind_reg     <= kind_n;
            out_cell_row_reg <= cell_row_n;
            out_cell_col_reg <= cell_col_n;
            out_word_reg     <= word_n;
            out_cur_row_reg  <= row_next;
            out_cur_col_reg  <= col_next;
            out_addr_reg     <= addr_n;
            out_last_reg     <= done;
        end
    end

    // Result ports.
    assign m_valid       = out_valid_reg;
    assign m_kind        = out_kind_reg;
    assign m_cell_row    = 5'(out_cell_row_reg);
    assign m_cell_col    = 7'(out_cell_col_reg);
    assign m_cell_word   = out_word_reg;
    assign m_cursor_row  = 5'(out_cur_row_reg);
    assign m_cursor_col  = 7'(out_cur_col_reg);
    assign m_cursor_addr = 11'(out_addr_reg);
    assign m_last        = out_last_reg;

endmodule

`default_nettype wire
